// ===== src/scr_pkg.sv =====
// shared types, phrase tables and step functions for the serial command recognizer
// no dependencies; used by scr_front, scr_queue, scr_back and the top level
package scr_pkg;

  localparam int NPHRASE = 17;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // command codes
  localparam logic [4:0] CMD_SERVO_ANGLE = 5'd4;
  localparam logic [4:0] CMD_SERVO_MAX = 5'd3;
  localparam logic [4:0] CMD_UNKNOWN = 5'd15;
  localparam logic [4:0] CMD_EMPTY = 5'd16;

  // servo number parser phases
  localparam logic [2:0] PH_PREFIX = 3'd0;
  localparam logic [2:0] PH_WS = 3'd1;
  localparam logic [2:0] PH_SIGN = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_FAIL = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  localparam logic [9:0] NUM_CAP = 10'd1023;

  // phrases padded to 16 characters, first character in the top byte
  localparam logic [127:0] PHRASE_TEXT [NPHRASE] = '{
    "servo off       ",
    "servo on        ",
    "servo sweep on  ",
    "servo sweep off ",
    "servo stop      ",
    "light on        ",
    "light off       ",
    "light toggle    ",
    "light blink     ",
    "fan on          ",
    "fan off         ",
    "pump on         ",
    "pump off        ",
    "mode auto       ",
    {"set", "_mode auto   "},
    "mode manual     ",
    {"set", "_mode manual "}
  };

  localparam logic [3:0] PHRASE_LEN [NPHRASE] = '{
    4'd9, 4'd8, 4'd14, 4'd15, 4'd10, 4'd8, 4'd9, 4'd12, 4'd11,
    4'd6, 4'd7, 4'd7, 4'd8, 4'd9, 4'd13, 4'd11, 4'd15
  };

  localparam logic [4:0] PHRASE_CODE [NPHRASE] = '{
    5'd0, 5'd1, 5'd2, 5'd3, 5'd3, 5'd5, 5'd6, 5'd7, 5'd8,
    5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd13, 5'd14, 5'd14
  };

  // one normalized item handed from front to back
  typedef struct packed {
    logic       has_space;
    logic       has_char;
    logic [7:0] ch;
    logic       last;
  } q_entry_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [9:0] value;
    logic       negative;
  } num_t;

  function automatic logic [7:0] servo_prefix(logic [3:0] p);
    logic [7:0] r;
    unique case (p)
      4'd0: r = "s";
      4'd1: r = "e";
      4'd2: r = "r";
      4'd3: r = "v";
      4'd4: r = "o";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
           (c == 8'h0C) || (c == 8'h0D);
  endfunction

  // drop every phrase that is too short or whose character at this position differs
  function automatic logic [NPHRASE-1:0] phrase_step(logic [NPHRASE-1:0] alive,
                                                      logic [3:0] pos4, logic big,
                                                      logic [7:0] c);
    logic [NPHRASE-1:0] r;
    r = alive;
    for (int k = 0; k < NPHRASE; k++) begin
      if (big || (pos4 >= PHRASE_LEN[k]) ||
          (PHRASE_TEXT[k][8*(15-int'(pos4)) +: 8] != c)) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  // one character through the "servo N" parser
  function automatic num_t num_step(num_t s, logic [3:0] pos4, logic big, logic [7:0] c);
    num_t        r;
    logic        digit;
    logic [9:0]  dval;
    logic [13:0] v;
    r = s;
    digit = (c >= "0") && (c <= "9");
    dval = 10'(c) - 10'd48;
    v = 14'(s.value) * 14'd10 + 14'(dval);
    unique case (s.phase)
      PH_PREFIX: begin
        if (!big && (pos4 < 4'd5) && (c == servo_prefix(pos4))) begin
          r.phase = (pos4 == 4'd4) ? PH_WS : PH_PREFIX;
        end else begin
          r.phase = PH_FAIL;
        end
      end
      PH_WS: begin
        if (is_ws(c)) begin
          r.phase = PH_WS;
        end else if (c == "+") begin
          r.phase = PH_SIGN;
        end else if (c == "-") begin
          r.phase = PH_SIGN;
          r.negative = 1'b1;
        end else if (digit) begin
          r.phase = PH_DIGITS;
          r.value = dval;
        end else begin
          r.phase = PH_FAIL;
        end
      end
      PH_SIGN: begin
        if (digit) begin
          r.phase = PH_DIGITS;
          r.value = dval;
        end else begin
          r.phase = PH_FAIL;
        end
      end
      PH_DIGITS: begin
        if (digit) begin
          r.value = (v > 14'(NUM_CAP)) ? NUM_CAP : v[9:0];
        end else begin
          r.phase = PH_DONE;
        end
      end
      default: r = s;
    endcase
    return r;
  endfunction

endpackage

// ===== src/scr_front.sv =====
// front end: takes raw bytes, counts them and normalizes spacing and case
// depends on scr_pkg; pushes one entry per produced character or line end
module scr_front #(
  parameter int MAX_LINE = 47,
  parameter int POS_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] char_byte
  input  logic              s_tlast,   // line_end
  input  logic              q_full,
  output logic              q_push,
  output scr_pkg::q_entry_t q_data
);

  logic [POS_W-1:0] raw_count, raw_count_next;
  logic             after_space, after_space_next;
  logic             space_pending, space_pending_next;
  logic             string_ended, string_ended_next;
  logic             accept;
  logic [7:0]       c;

  assign s_tready = !q_full;
  assign accept = s_tvalid && s_tready;

  always_comb begin
    raw_count_next = raw_count;
    after_space_next = after_space;
    space_pending_next = space_pending;
    string_ended_next = string_ended;
    q_data = '0;
    q_data.last = s_tlast;
    c = s_tdata;
    if (c == 8'h09) begin
      c = 8'h20;
    end
    if ((c >= "A") && (c <= "Z")) begin
      c = c + 8'd32;
    end
    q_data.ch = c;
    if (!string_ended && (raw_count < POS_W'(MAX_LINE))) begin
      raw_count_next = raw_count + POS_W'(1);
      if (s_tdata == 8'h00) begin
        string_ended_next = 1'b1;
      end else if (c == 8'h20) begin
        if (!after_space) begin
          space_pending_next = 1'b1;
        end
        after_space_next = 1'b1;
      end else begin
        q_data.has_space = space_pending;
        q_data.has_char = 1'b1;
        space_pending_next = 1'b0;
        after_space_next = 1'b0;
      end
    end
    q_push = accept && (q_data.has_char || s_tlast);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      raw_count <= '0;
      after_space <= 1'b1;
      space_pending <= 1'b0;
      string_ended <= 1'b0;
    end else if (accept) begin
      raw_count <= raw_count_next;
      after_space <= after_space_next;
      space_pending <= space_pending_next;
      string_ended <= string_ended_next;
    end
  end

endmodule

// ===== src/scr_queue.sv =====
// short register queue between front and back
// depends on scr_pkg for the entry type and depth
module scr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  scr_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output scr_pkg::q_entry_t head
);

  scr_pkg::q_entry_t         entries [scr_pkg::QDEPTH];
  logic [scr_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [scr_pkg::QPTR_W:0]   count;

  assign full = (count == (scr_pkg::QPTR_W+1)'(scr_pkg::QDEPTH));
  assign valid = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/scr_back.sv =====
// back end: phrase matching, servo number parsing and the result register
// depends on scr_pkg for tables, step functions and command codes
module scr_back #(
  parameter int POS_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  scr_pkg::q_entry_t q_head,
  output logic              q_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata    // [4:0] command_code, [12:5] servo_angle
);

  logic [scr_pkg::NPHRASE-1:0] alive, alive1, alive2;
  logic [POS_W-1:0]            pos, pos1, pos2;
  scr_pkg::num_t               num, num1, num2;
  logic                        matched;
  logic [4:0]                  mcode, code;
  logic [7:0]                  angle;
  logic                        num_ok;

  assign q_pop = q_valid && (!q_head.last || !m_tvalid || m_tready);

  always_comb begin
    // held space first, then the character at the next position
    alive1 = alive;
    num1 = num;
    pos1 = pos;
    if (q_head.has_space) begin
      alive1 = scr_pkg::phrase_step(alive, pos[3:0], |pos[POS_W-1:4], 8'h20);
      num1 = scr_pkg::num_step(num, pos[3:0], |pos[POS_W-1:4], 8'h20);
      pos1 = pos + POS_W'(1);
    end
    alive2 = alive1;
    num2 = num1;
    pos2 = pos1;
    if (q_head.has_char) begin
      alive2 = scr_pkg::phrase_step(alive1, pos1[3:0], |pos1[POS_W-1:4], q_head.ch);
      num2 = scr_pkg::num_step(num1, pos1[3:0], |pos1[POS_W-1:4], q_head.ch);
      pos2 = pos1 + POS_W'(1);
    end

    matched = 1'b0;
    mcode = scr_pkg::CMD_UNKNOWN;
    for (int k = 0; k < scr_pkg::NPHRASE; k++) begin
      if (alive2[k] && (pos2 == POS_W'(scr_pkg::PHRASE_LEN[k]))) begin
        matched = 1'b1;
        mcode = scr_pkg::PHRASE_CODE[k];
      end
    end

    num_ok = ((num2.phase == scr_pkg::PH_DIGITS) || (num2.phase == scr_pkg::PH_DONE)) &&
             ((num2.value == 10'd0) ||
              (!num2.negative && ((num2.value == 10'd90) || (num2.value == 10'd180))));

    angle = 8'd0;
    priority if (pos2 == '0) begin
      code = scr_pkg::CMD_EMPTY;
    end else if (matched && (mcode <= scr_pkg::CMD_SERVO_MAX)) begin
      code = mcode;
    end else if (num_ok) begin
      code = scr_pkg::CMD_SERVO_ANGLE;
      angle = num2.value[7:0];
    end else if (matched) begin
      code = mcode;
    end else begin
      code = scr_pkg::CMD_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (q_pop && q_head.last)) begin
      alive <= '1;
      pos <= '0;
      num <= '{phase: scr_pkg::PH_PREFIX, value: 10'd0, negative: 1'b0};
    end else if (q_pop) begin
      alive <= alive2;
      pos <= pos2;
      num <= num2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop && q_head.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.last) begin
      m_tdata <= {3'b000, angle, code};
    end
  end

endmodule

// ===== src/serial_command_recognizer.sv =====
// serial command recognizer: bytes of a command line in, one command code per line out
// Input channel s_*: one raw byte per item in s_tdata, s_tlast marks the line's last byte.
// Output channel m_*: one item per line, command code and servo angle in m_tdata.
// Bytes are normalized in the front end (tab to space, lowercase, space runs collapsed,
// leading and trailing spaces dropped, counting stops after MAX_LINE bytes or a zero byte).
// The back end compares against all phrases in parallel and parses "servo N".
// Throughput: one byte per cycle unless the queue is full; the back end consumes one
// queue entry per cycle unless a result waits on m_tready; an entry carries at most
// a held space and one character. Results pass the queue, then the output register.
// A four-entry queue sits between front and back; when m_tready is low the finished
// result stays in the output register, the back end keeps consuming non-final entries,
// and s_tready drops only once the queue fills.
// Reset (rst, synchronous) empties the queue and the output and starts a fresh line.
// No clearing pass is needed after reset.
// Depends on scr_pkg, scr_front, scr_queue and scr_back.
module serial_command_recognizer #(
  parameter int MAX_LINE = 47
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  input  logic        s_tlast,   // line_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [4:0] command_code, [12:5] servo_angle, [15:13] zero
);

  localparam int POS_W = $clog2(MAX_LINE + 1);

  logic              q_full, q_push, q_pop, q_valid;
  scr_pkg::q_entry_t q_data, q_head;

  scr_front #(
    .MAX_LINE(MAX_LINE),
    .POS_W(POS_W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(q_data)
  );

  scr_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_data(q_data),
    .full(q_full),
    .pop(q_pop),
    .valid(q_valid),
    .head(q_head)
  );

  scr_back #(
    .POS_W(POS_W)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_head(q_head),
    .q_pop(q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("queue push while full");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[4:0] <= scr_pkg::CMD_EMPTY))
    else $error("command code out of range");

  a_angle_only_servo: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[12:5] != 8'd0)) |-> (m_tdata[4:0] == scr_pkg::CMD_SERVO_ANGLE))
    else $error("servo angle set for a non-angle command");

  a_pop_has_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("queue pop while empty");
`endif

endmodule
